/* rtl/core/huffman_tree_table_decoder_core_macros.svh */
// Assertion macros for the checker file of the tree-table decoder.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef HUFFMAN_TREE_TABLE_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_TABLE_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define HTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder check failed in the following cycle");

`endif

/* rtl/core/htd_pkg.sv */
package htd_pkg;

   // Request actions.
   typedef enum logic [1:0] {
      ACTION_TREE_BYTE = 2'd0,
      ACTION_CODE_BIT  = 2'd1,
      ACTION_CLEAR     = 2'd2,
      ACTION_NONE      = 2'd3
   } action_type;

   // Response status codes.
   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_TREE_COMPLETE = 3'd1,
      STATUS_BAD_BYTE      = 3'd2,
      STATUS_OVERFLOW      = 3'd3,
      STATUS_NOT_READY     = 3'd4,
      STATUS_ALREADY_DONE  = 3'd5
   } status_type;

   // Tree description markers (ASCII digits).
   localparam logic [7:0] MARK_INTERNAL = 8'h30;
   localparam logic [7:0] MARK_LEAF     = 8'h31;

endpackage

/* rtl/core/huffman_tree_table_decoder_core.sv */
// Huffman tree-table decoder core.
// The request channel (req_valid / req_stall) carries one transaction per tree
// description byte, code bit or clear command, selected by req_action. Every
// accepted request transaction produces exactly one response transaction on the
// rsp_ channel, holding the decoded symbol (when a leaf was reached), a status
// code and the tree-ready flag.
// The response is registered at the edge that accepts the request. A code bit
// can be followed at once by the next request, since the walk reads one
// node-link entry per bit and the next read address comes straight from that
// read data. A tree byte that changes the depth of the open-parent stack sets
// settle_ff, which stalls the next request, because the next stack entry is
// fetched from the stack memory with a registered read; so does the completing
// byte unless the whole tree is a single leaf, and a clear on a non-empty stack.
// Reset is synchronous and clears the tree: no tree is held, the walk sits at
// the root and no response is pending. The node-link and stack memories are not
// cleared; a tree is fully rewritten before it can be decoded.
// When the receiver holds rsp_stall high the response register keeps its
// transaction and req_stall is raised, so no request is lost. A request can be
// accepted in the same cycle in which the pending response is taken.
module huffman_tree_table_decoder_core #(
   parameter int MAX_NODES   = 512,
   parameter int STACK_DEPTH = 256,
   parameter int SYMBOL_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_tree_byte,
   input  logic       req_code_bit,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_symbol_valid,
   output logic [7:0] rsp_symbol,
   output logic [2:0] rsp_status,
   output logic       rsp_tree_ready
);

   localparam int NodeIdxW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NodeCntW   = $clog2(MAX_NODES + 1);
   localparam int StackAddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int StackCntW  = $clog2(STACK_DEPTH + 1);
   // Only the low SYMBOL_BITS bits of a tree byte, at most eight, can reach the symbol.
   localparam int SymW       = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;

   // One half of a link entry: the child index plus a copy of the child's leaf
   // flag and symbol, so that a single read per code bit is enough.
   typedef struct packed {
      logic                leaf;
      logic [SymW-1:0]     sym;
      logic [NodeIdxW-1:0] idx;
   } link_type;

   // Node-link memory: half 0 is the left child, half 1 the right child.
   link_type [1:0] link_mem [MAX_NODES];
   // Open parents below the top of the stack; the top lives in top_ff.
   logic [NodeIdxW-1:0] stack_mem [STACK_DEPTH];

   logic                      accept;

   logic [NodeCntW-1:0]       count_ff, count_in;
   logic [StackCntW-1:0]      depth_ff, depth_in;
   logic [NodeIdxW-1:0]       top_ff, top_in;
   logic                      top_left_set_ff, top_left_set_in;
   logic                      expect_symbol_ff, expect_symbol_in;
   logic                      complete_ff, complete_in;
   logic [NodeIdxW-1:0]       walk_ff, walk_in;
   logic                      settle_ff, settle_in;
   logic                      root_leaf_ff, root_leaf_in;
   logic [SymW-1:0]           root_sym_ff, root_sym_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_symbol_valid_ff, rsp_symbol_valid_in;
   logic [7:0]                rsp_symbol_ff, rsp_symbol_in;
   htd_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic                      rsp_tree_ready_ff, rsp_tree_ready_in;

   link_type [1:0]            link_rd_ff;
   logic [NodeIdxW-1:0]       stack_rd_ff;
   logic [StackCntW-1:0]      stack_rd_full;

   logic                      link_we_left, link_we_right;
   logic [NodeIdxW-1:0]       link_wr_addr;
   link_type                  link_wr_data;
   logic                      stack_we;
   logic [StackAddrW-1:0]     stack_wr_addr;
   logic [NodeIdxW-1:0]       stack_wr_data;

   // Node creation request from the tree-byte decode.
   logic                      add_node;
   logic                      add_leaf;
   logic [SymW-1:0]           add_sym;
   logic [StackCntW-1:0]      depth_after_attach;
   logic [StackCntW-1:0]      depth_v;
   logic [StackCntW-1:0]      stack_wr_full;
   logic [NodeIdxW-1:0]       top_v;
   logic                      top_left_set_v;
   link_type                  walk_half;

   assign req_stall = settle_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Entry just below the top of the stack; its registered read is stale after a
   // depth change, and settle_ff stalls the next request until it is valid.
   assign stack_rd_full = depth_ff - StackCntW'(2);

   // Depth the stack would have once the next node is attached to its parent.
   assign depth_after_attach =
      (count_ff != '0 && depth_ff != '0 && top_left_set_ff) ?
      StackCntW'(depth_ff - 1'b1) : depth_ff;

   assign walk_half = req_code_bit ? link_rd_ff[1] : link_rd_ff[0];

   always_comb begin
      count_in            = count_ff;
      depth_in            = depth_ff;
      top_in              = top_ff;
      top_left_set_in     = top_left_set_ff;
      expect_symbol_in    = expect_symbol_ff;
      complete_in         = complete_ff;
      walk_in             = walk_ff;
      root_leaf_in        = root_leaf_ff;
      root_sym_in         = root_sym_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_symbol_valid_in = rsp_symbol_valid_ff;
      rsp_symbol_in       = rsp_symbol_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_tree_ready_in   = rsp_tree_ready_ff;
      link_we_left        = 1'b0;
      link_we_right       = 1'b0;
      link_wr_addr        = top_ff;
      link_wr_data        = '0;
      stack_we            = 1'b0;
      stack_wr_full       = '0;
      stack_wr_addr       = '0;
      stack_wr_data       = top_ff;
      add_node            = 1'b0;
      add_leaf            = 1'b0;
      add_sym             = '0;
      depth_v             = depth_ff;
      top_v               = top_ff;
      top_left_set_v      = top_left_set_ff;

      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_symbol_valid_in = 1'b0;
         rsp_symbol_in       = '0;
         rsp_status_in       = htd_pkg::STATUS_OK;

         unique case (htd_pkg::action_type'(req_action))
            htd_pkg::ACTION_TREE_BYTE: begin
               if (complete_ff) begin
                  rsp_status_in = htd_pkg::STATUS_ALREADY_DONE;
               end else if (expect_symbol_ff) begin
                  expect_symbol_in = 1'b0;
                  add_node         = 1'b1;
                  add_leaf         = 1'b1;
                  add_sym          = req_tree_byte[SymW-1:0];
               end else if (req_tree_byte == htd_pkg::MARK_LEAF) begin
                  if (count_ff >= NodeCntW'(MAX_NODES)) begin
                     rsp_status_in = htd_pkg::STATUS_OVERFLOW;
                  end else begin
                     expect_symbol_in = 1'b1;
                  end
               end else if (req_tree_byte == htd_pkg::MARK_INTERNAL) begin
                  if (count_ff >= NodeCntW'(MAX_NODES) ||
                      depth_after_attach >= StackCntW'(STACK_DEPTH)) begin
                     rsp_status_in = htd_pkg::STATUS_OVERFLOW;
                  end else begin
                     add_node = 1'b1;
                  end
               end else begin
                  rsp_status_in = htd_pkg::STATUS_BAD_BYTE;
               end
            end
            htd_pkg::ACTION_CODE_BIT: begin
               if (!complete_ff) begin
                  rsp_status_in = htd_pkg::STATUS_NOT_READY;
               end else if (root_leaf_ff) begin
                  // A tree of one leaf emits that leaf for every bit.
                  rsp_symbol_valid_in = 1'b1;
                  rsp_symbol_in       = 8'(root_sym_ff);
               end else if (walk_half.leaf) begin
                  rsp_symbol_valid_in = 1'b1;
                  rsp_symbol_in       = 8'(walk_half.sym);
                  walk_in             = '0;
               end else begin
                  walk_in = walk_half.idx;
               end
            end
            htd_pkg::ACTION_CLEAR: begin
               count_in         = '0;
               depth_in         = '0;
               expect_symbol_in = 1'b0;
               complete_in      = 1'b0;
               walk_in          = '0;
            end
            htd_pkg::ACTION_NONE: begin
            end
         endcase

         if (add_node) begin
            if (count_ff >= NodeCntW'(MAX_NODES)) begin
               rsp_status_in = htd_pkg::STATUS_OVERFLOW;
            end else begin
               link_wr_data = '{leaf: add_leaf, sym: add_sym,
                                idx: count_ff[NodeIdxW-1:0]};
               // Attach to the open parent: left first, then right and pop.
               if (count_ff != '0 && depth_ff != '0) begin
                  if (!top_left_set_ff) begin
                     link_we_left   = 1'b1;
                     top_left_set_v = 1'b1;
                  end else begin
                     link_we_right  = 1'b1;
                     depth_v        = StackCntW'(depth_ff - 1'b1);
                     top_v          = stack_rd_ff;
                     // Every parent below the top already has its left child.
                     top_left_set_v = 1'b1;
                  end
               end
               if (count_ff == '0) begin
                  root_leaf_in = add_leaf;
                  root_sym_in  = add_sym;
               end
               count_in = NodeCntW'(count_ff + 1'b1);
               if (!add_leaf) begin
                  if (depth_v != '0) begin
                     stack_we      = 1'b1;
                     stack_wr_full = StackCntW'(depth_v - 1'b1);
                     stack_wr_addr = stack_wr_full[StackAddrW-1:0];
                     stack_wr_data = top_v;
                  end
                  top_v          = count_ff[NodeIdxW-1:0];
                  top_left_set_v = 1'b0;
                  depth_v        = StackCntW'(depth_v + 1'b1);
               end
               depth_in        = depth_v;
               top_in          = top_v;
               top_left_set_in = top_left_set_v;
               if (depth_v == '0) begin
                  complete_in   = 1'b1;
                  walk_in       = '0;
                  rsp_status_in = htd_pkg::STATUS_TREE_COMPLETE;
               end
            end
         end

         rsp_tree_ready_in = complete_in;
      end

      // A depth change leaves the registered stack read stale; settle_ff covers it.
      settle_in = accept && (depth_in != depth_ff);
   end

   // Memories: registered reads; the link read follows the next walk position.
   always_ff @(posedge clock) begin
      if (link_we_left) begin
         link_mem[link_wr_addr][0] <= link_wr_data;
      end
      if (link_we_right) begin
         link_mem[link_wr_addr][1] <= link_wr_data;
      end
      link_rd_ff <= link_mem[walk_in];
      if (stack_we) begin
         stack_mem[stack_wr_addr] <= stack_wr_data;
      end
      stack_rd_ff <= stack_mem[stack_rd_full[StackAddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         depth_ff         <= '0;
         top_left_set_ff  <= 1'b0;
         expect_symbol_ff <= 1'b0;
         complete_ff      <= 1'b0;
         walk_ff          <= '0;
         settle_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         depth_ff         <= depth_in;
         top_left_set_ff  <= top_left_set_in;
         expect_symbol_ff <= expect_symbol_in;
         complete_ff      <= complete_in;
         walk_ff          <= walk_in;
         settle_ff        <= settle_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      top_ff              <= top_in;
      root_leaf_ff        <= root_leaf_in;
      root_sym_ff         <= root_sym_in;
      rsp_symbol_valid_ff <= rsp_symbol_valid_in;
      rsp_symbol_ff       <= rsp_symbol_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_tree_ready_ff   <= rsp_tree_ready_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_valid = rsp_symbol_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_tree_ready   = rsp_tree_ready_ff;

endmodule

/* rtl/core/htd_checker.sv */
`include "huffman_tree_table_decoder_core_macros.svh"

module htd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_symbol_valid,
   input logic [7:0] rsp_symbol,
   input logic [2:0] rsp_status,
   input logic       rsp_tree_ready
);

   // A stalled response transaction is held.
   `HTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A decoded symbol only comes from a complete tree with an ok status.
   `HTD_ASSERT_SAME(a_symbol_ok, clock, reset, rsp_valid && rsp_symbol_valid,
      rsp_tree_ready && rsp_status == htd_pkg::STATUS_OK)

   // Without a symbol the symbol field reads as zero.
   `HTD_ASSERT_SAME(a_symbol_zero, clock, reset, rsp_valid && !rsp_symbol_valid,
      rsp_symbol == 8'd0)

   // A bit refused for lack of a tree reports no tree.
   `HTD_ASSERT_SAME(a_not_ready, clock, reset,
      rsp_valid && rsp_status == htd_pkg::STATUS_NOT_READY,
      !rsp_tree_ready && !rsp_symbol_valid)

   // A clear transaction answers in the next cycle with an empty tree.
   `HTD_ASSERT_NEXT(a_clear, clock, reset,
      req_valid && !req_stall && req_action == htd_pkg::ACTION_CLEAR,
      rsp_valid && !rsp_tree_ready && rsp_status == htd_pkg::STATUS_OK)

endmodule

bind huffman_tree_table_decoder_core htd_checker u_htd_checker (.*);
